// File: rtl/ivfp_pkg.sv
package ivfp_pkg;

    // Capture window and fixed header geometry
    localparam int STORE_DEPTH   = 44;
    localparam int FILE_HDR_LEN  = 32;
    localparam int FRAME_HDR_LEN = 12;

    // Start of frame data, with and without a file header
    localparam logic [5:0] OFFSET_BARE = 6'd12;
    localparam logic [5:0] OFFSET_HDR  = 6'd44;

    // Four-character codes, element 0 is the first byte on the wire
    localparam logic [3:0][7:0] TAG_DKIF = {8'h46, 8'h49, 8'h4B, 8'h44};
    localparam logic [3:0][7:0] TAG_VP90 = {8'h30, 8'h39, 8'h50, 8'h56};

    typedef logic [STORE_DEPTH-1:0][7:0] capture_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic        frame_ok;
        logic        header_present;
        logic [15:0] video_width;
        logic [15:0] video_height;
        logic [31:0] rate_numerator;
        logic [31:0] rate_denominator;
        logic [31:0] frames_in_file;
        logic [31:0] frame_length;
        logic [63:0] frame_timestamp;
        logic [5:0]  data_offset;
    } result_t;

    // File header fields
    typedef struct packed {
        logic [15:0] video_width;
        logic [15:0] video_height;
        logic [31:0] rate_numerator;
        logic [31:0] rate_denominator;
        logic [31:0] frames_in_file;
    } hdr_info_t;

    // Frame header fields
    typedef struct packed {
        logic [31:0] frame_length;
        logic [63:0] frame_timestamp;
    } frame_hdr_t;

    // Classified payload, handed from front to back
    typedef struct packed {
        logic       header_present;
        hdr_info_t  info;
        frame_hdr_t frm;
    } verdict_t;

endpackage

// File: rtl/ivf_payload_frame_parser_unit.sv
// Accepts one payload byte per clock; input stalls only when the result side backs up.
// Result appears on m_valid after the transfer of the final byte: the record enters
// the two-entry queue, then the output register once the result side can take it.
// Verdict logic in the back end keeps pace with one payload per cycle while the result side is not backed up.
// Reset (aresetn low at a clock edge) clears the byte count, queue and output valid;
// the 44-byte capture window is not cleared and needs no startup pass.
module ivf_payload_frame_parser_unit #(
    parameter int COUNT_WIDTH = 34
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ivfp_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ivfp_pkg::result_t   m_data
);
    import ivfp_pkg::*;

    localparam int REC_W = $bits(verdict_t) + COUNT_WIDTH;

    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;
    logic                   push_valid;
    verdict_t               push_verdict;
    logic [COUNT_WIDTH-1:0] push_len;
    logic [REC_W-1:0]       q_rd_data;
    verdict_t               q_verdict;
    logic [COUNT_WIDTH-1:0] q_len;

    // Capture bytes and classify the file header
    ivfp_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .q_full       (q_full),
        .push_valid   (push_valid),
        .push_verdict (push_verdict),
        .push_len     (push_len)
    );

    // Decouple front and back
    ivfp_fifo #(
        .WIDTH (REC_W)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (push_valid),
        .wr_data ({push_verdict, push_len}),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    assign {q_verdict, q_len} = q_rd_data;

    // Judge the frame and drive the result channel
    ivfp_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (!q_empty),
        .q_pop     (q_pop),
        .q_verdict (q_verdict),
        .q_len     (q_len),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: rtl/ivfp_front.sv
module ivfp_front #(
    parameter int COUNT_WIDTH = 34
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ivfp_pkg::in_beat_t     s_data,
    input  logic                   q_full,
    output logic                   push_valid,
    output ivfp_pkg::verdict_t     push_verdict,
    output logic [COUNT_WIDTH-1:0] push_len
);
    import ivfp_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] cnt_next;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    capture_t               store_reg;
    capture_t               store_next;
    logic                   accept;
    logic                   hdr_ok;
    logic                   tags_ok;

    function automatic logic [15:0] le16(input capture_t s, input int at);
        return {s[at+1], s[at]};
    endfunction

    function automatic logic [31:0] le32(input capture_t s, input int at);
        return {s[at+3], s[at+2], s[at+1], s[at]};
    endfunction

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Saturating byte count including the current byte
    assign cnt_inc = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + COUNT_WIDTH'(1);

    always_comb begin
        cnt_next = cnt_reg;
        if (accept) begin
            cnt_next = s_data.last_byte ? '0 : cnt_inc;
        end
    end

    // Merge the current byte into the capture window
    always_comb begin
        store_next = store_reg;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            if (cnt_reg == COUNT_WIDTH'(i)) begin
                store_next[i] = s_data.data_byte;
            end
        end
    end

    // Classify the file header on the final byte
    always_comb begin
        tags_ok = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (store_next[i] != TAG_DKIF[i] || store_next[8+i] != TAG_VP90[i]) begin
                tags_ok = 1'b0;
            end
        end
    end

    assign hdr_ok = (cnt_inc >= COUNT_WIDTH'(FILE_HDR_LEN)) && tags_ok
                 && (le16(store_next, 6) == 16'(FILE_HDR_LEN))
                 && (le16(store_next, 12) != '0) && (le16(store_next, 14) != '0)
                 && (le32(store_next, 16) != '0) && (le32(store_next, 20) != '0);

    // Build the record pushed into the queue
    always_comb begin
        push_verdict.header_present         = hdr_ok;
        push_verdict.info.video_width       = le16(store_next, 12);
        push_verdict.info.video_height      = le16(store_next, 14);
        push_verdict.info.rate_numerator    = le32(store_next, 16);
        push_verdict.info.rate_denominator  = le32(store_next, 20);
        push_verdict.info.frames_in_file    = le32(store_next, 24);
        if (hdr_ok) begin
            push_verdict.frm.frame_length    = le32(store_next, FILE_HDR_LEN);
            push_verdict.frm.frame_timestamp = {le32(store_next, FILE_HDR_LEN + 8),
                                                le32(store_next, FILE_HDR_LEN + 4)};
        end else begin
            push_verdict.frm.frame_length    = le32(store_next, 0);
            push_verdict.frm.frame_timestamp = {le32(store_next, 8), le32(store_next, 4)};
        end
    end

    assign push_valid = accept && s_data.last_byte;
    assign push_len   = cnt_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Capture bytes, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            store_reg <= store_next;
        end
    end

`ifndef SYNTHESIS
    a_count_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |=> cnt_reg == '0)
        else $error("byte count did not restart after final byte");

    a_hdr_needs_len: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid && push_verdict.header_present
            |-> push_len >= COUNT_WIDTH'(FILE_HDR_LEN))
        else $error("file header accepted on a short payload");
`endif

endmodule

// File: rtl/ivfp_fifo.sv
module ivfp_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_en ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en) begin
            count_next = count_reg + 2'd1;
        end else if (!wr_en && rd_en) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && full) && !(rd_en && empty))
        else $error("queue overflow or underflow");
`endif

endmodule

// File: rtl/ivfp_back.sv
module ivfp_back #(
    parameter int COUNT_WIDTH = 34
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_pop,
    input  ivfp_pkg::verdict_t     q_verdict,
    input  logic [COUNT_WIDTH-1:0] q_len,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ivfp_pkg::result_t      m_data
);
    import ivfp_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > 32 ? COUNT_WIDTH : 32) + 1;

    logic              m_valid_reg;
    logic              m_valid_next;
    result_t           m_data_reg;
    result_t           m_data_next;
    logic [5:0]        data_end;
    logic [CMP_W-1:0]  need;
    logic              fits;

    // Frame fits when its header lies inside the payload and size plus
    // header end does not pass the payload length
    assign data_end = q_verdict.header_present ? OFFSET_HDR : OFFSET_BARE;
    assign need     = CMP_W'(q_verdict.frm.frame_length) + CMP_W'(data_end);
    assign fits     = (q_len >= COUNT_WIDTH'(data_end)) && (need <= CMP_W'(q_len));

    assign q_pop = q_valid && (!m_valid_reg || m_ready);

    // Format the result, zero the fields that do not apply
    always_comb begin
        m_data_next                = '0;
        m_data_next.frame_ok       = fits;
        m_data_next.header_present = q_verdict.header_present;
        m_data_next.data_offset    = data_end;
        if (q_verdict.header_present) begin
            m_data_next.video_width      = q_verdict.info.video_width;
            m_data_next.video_height     = q_verdict.info.video_height;
            m_data_next.rate_numerator   = q_verdict.info.rate_numerator;
            m_data_next.rate_denominator = q_verdict.info.rate_denominator;
            m_data_next.frames_in_file   = q_verdict.info.frames_in_file;
        end
        if (fits) begin
            m_data_next.frame_length    = q_verdict.frm.frame_length;
            m_data_next.frame_timestamp = q_verdict.frm.frame_timestamp;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (q_pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the result until the transfer completes
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_offset_follows_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.header_present && m_data_reg.data_offset == OFFSET_HDR)
                     || (!m_data_reg.header_present && m_data_reg.data_offset == OFFSET_BARE))
        else $error("data offset disagrees with header flag");

    a_bad_frame_zeroed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.frame_ok
            |-> m_data_reg.frame_length == '0 && m_data_reg.frame_timestamp == '0)
        else $error("frame fields not cleared on a bad frame");
`endif

endmodule
